// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on aclk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IGT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IGT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/igt_pkg.sv =====
package igt_pkg;

    localparam int DIM_W     = 7;
    localparam int ARG_W     = 6;
    localparam int MODE_W    = 3;
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 12;
    localparam int OUT_DIM_W = 13;
    localparam int IDX_W     = 14;

    localparam logic [OUT_DIM_W-1:0] COORD_LIMIT = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_CW   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CCW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PAD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TILE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CROP = 3'd4;

    localparam logic OP_PULL = 1'b1;

    localparam logic [2:0] REG_IMAGE_ROWS = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS = 3'd1;
    localparam logic [2:0] REG_MODE       = 3'd2;
    localparam logic [2:0] REG_ARG_ROW    = 3'd3;
    localparam logic [2:0] REG_ARG_COL    = 3'd4;
    localparam logic [2:0] REG_ARG_ROWS   = 3'd5;
    localparam logic [2:0] REG_ARG_COLS   = 3'd6;
    localparam logic [2:0] REG_PAD_VALUE  = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]  image_rows;
        logic [DIM_W-1:0]  image_cols;
        logic [MODE_W-1:0] transform_mode;
        logic [ARG_W-1:0]  arg_row;
        logic [ARG_W-1:0]  arg_col;
        logic [DIM_W-1:0]  arg_rows;
        logic [DIM_W-1:0]  arg_cols;
        logic [PIX_W-1:0]  pad_value;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic geom;
        logic write;
        logic check;
        logic rem_start;
        logic src;
        logic addr;
        logic read;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pull;
        logic err;
        logic tile;
        logic rem_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hdl/igt_rem.sv =====
module igt_rem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [igt_pkg::COORD_W-1:0] dividend,
    input  logic [igt_pkg::DIM_W-1:0]   divisor,
    output logic                        done,
    output logic [igt_pkg::DIM_W-1:0]   remainder
);
    import igt_pkg::*;

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [COORD_W-1:0]  quo_reg;
    logic [DIM_W-1:0]    rem_reg;
    logic [DIM_W-1:0]    div_reg;
    logic [DIM_W:0]      trial;
    logic [DIM_W-1:0]    rem_next;

    // one restoring step per cycle
    assign trial = {rem_reg, quo_reg[COORD_W-1]};

    always_comb begin
        if (trial >= {1'b0, div_reg}) begin
            rem_next = DIM_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[COORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/igt_ctrl.sv =====
module igt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  igt_pkg::ctrl_sts_t    sts,
    output igt_pkg::ctrl_cmd_t    cmd
);
    import igt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GEOM = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_PLAN = 4'd4;
    localparam logic [3:0] S_REMW = 4'd5;
    localparam logic [3:0] S_SRC  = 4'd6;
    localparam logic [3:0] S_ADDR = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_GEOM;
                end
            end
            S_GEOM: begin
                cmd.geom   = 1'b1;
                state_next = sts.is_pull ? S_CHK : S_WR;
            end
            S_WR: begin
                cmd.write  = 1'b1;
                state_next = S_IDLE;
            end
            S_CHK: begin
                cmd.check  = 1'b1;
                state_next = S_PLAN;
            end
            S_PLAN: begin
                if (sts.err) begin
                    state_next = S_OUT;
                end else if (sts.tile) begin
                    cmd.rem_start = 1'b1;
                    state_next    = S_REMW;
                end else begin
                    state_next = S_SRC;
                end
            end
            S_REMW: begin
                if (sts.rem_done) begin
                    state_next = S_SRC;
                end
            end
            S_SRC: begin
                cmd.src    = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/igt_dp.sv =====
`include "assert_macros.svh"

module igt_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int OUT_MAX  = 4096
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  igt_pkg::cfg_t             cfg,
    input  igt_pkg::ctrl_cmd_t        cmd,
    output igt_pkg::ctrl_sts_t        sts,
    input  logic [igt_pkg::PIX_W-1:0] s_tdata,
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);
    import igt_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0]       r_dim;
    logic [DIM_W-1:0]       c_dim;

    logic                   op_reg;
    logic [PIX_W-1:0]       pix_reg;

    logic [IDX_W-1:0]       rc_reg;
    logic [OUT_DIM_W-1:0]   orows_reg;
    logic [OUT_DIM_W-1:0]   ocols_reg;
    logic                   arg_err_reg;
    logic [OUT_DIM_W-1:0]   orows_next;
    logic [OUT_DIM_W-1:0]   ocols_next;
    logic                   arg_err_next;
    logic [DIM_W:0]         crop_row_end;
    logic [DIM_W:0]         crop_col_end;

    logic [2*OUT_DIM_W-1:0] out_area;
    logic                   err_reg;
    logic [COORD_W-1:0]     a_reg;
    logic [COORD_W-1:0]     b_reg;
    logic [COORD_W-1:0]     pull_row_reg;
    logic [COORD_W-1:0]     pull_col_reg;
    logic [IDX_W-1:0]       load_idx_reg;
    logic [IDX_W-1:0]       load_base;
    logic [IDX_W-1:0]       load_inc;

    logic                   rem_done;
    logic                   rem_done_row;
    logic                   rem_done_col;
    logic [DIM_W-1:0]       rem_a;
    logic [DIM_W-1:0]       rem_b;

    logic [DIM_W-1:0]       src_r_reg;
    logic [DIM_W-1:0]       src_c_reg;
    logic                   pad_sel_reg;
    logic [DIM_W-1:0]       src_r_next;
    logic [DIM_W-1:0]       src_c_next;
    logic                   pad_sel_next;
    logic [COORD_W-1:0]     pad_lo;
    logic                   pad_inside;

    logic [IDX_W-1:0]       addr_sum;
    logic [AW-1:0]          addr_reg;
    logic [PIX_W-1:0]       rdata_reg;
    logic [PIX_W-1:0]       mem [DEPTH];

    logic [OUT_DIM_W-1:0]   a_inc;
    logic [OUT_DIM_W-1:0]   b_inc;
    logic                   last_px;

    logic                   m_valid_reg;
    logic [PIX_W-1:0]       m_pix_reg;
    logic [COORD_W-1:0]     m_row_reg;
    logic [COORD_W-1:0]     m_col_reg;
    logic                   m_last_reg;
    logic                   m_err_reg;

    logic                   err_item_clean;
    logic                   pull_in_range;
    logic                   rem_in_range;

    // image size clamped to 1..max
    always_comb begin
        if (cfg.image_rows == '0) begin
            r_dim = DIM_W'(1);
        end else if (int'(cfg.image_rows) > MAX_ROWS) begin
            r_dim = DIM_W'(MAX_ROWS);
        end else begin
            r_dim = cfg.image_rows;
        end
        if (cfg.image_cols == '0) begin
            c_dim = DIM_W'(1);
        end else if (int'(cfg.image_cols) > MAX_COLS) begin
            c_dim = DIM_W'(MAX_COLS);
        end else begin
            c_dim = cfg.image_cols;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_tuser;
            pix_reg <= s_tdata;
        end
    end

    // output geometry
    assign crop_row_end = (DIM_W+1)'(cfg.arg_row) + (DIM_W+1)'(cfg.arg_rows);
    assign crop_col_end = (DIM_W+1)'(cfg.arg_col) + (DIM_W+1)'(cfg.arg_cols);

    always_comb begin
        orows_next   = '0;
        ocols_next   = '0;
        arg_err_next = 1'b0;
        case (cfg.transform_mode) inside
            MODE_CW, MODE_CCW: begin
                orows_next = OUT_DIM_W'(c_dim);
                ocols_next = OUT_DIM_W'(r_dim);
            end
            MODE_PAD: begin
                orows_next = OUT_DIM_W'(r_dim) + OUT_DIM_W'({cfg.arg_row, 1'b0});
                ocols_next = OUT_DIM_W'(c_dim) + OUT_DIM_W'({cfg.arg_row, 1'b0});
            end
            MODE_TILE: begin
                orows_next   = OUT_DIM_W'(cfg.arg_row) * OUT_DIM_W'(r_dim);
                ocols_next   = OUT_DIM_W'(cfg.arg_col) * OUT_DIM_W'(c_dim);
                arg_err_next = (cfg.arg_row == '0) || (cfg.arg_col == '0);
            end
            MODE_CROP: begin
                orows_next   = OUT_DIM_W'(cfg.arg_rows);
                ocols_next   = OUT_DIM_W'(cfg.arg_cols);
                arg_err_next = (cfg.arg_rows == '0) || (cfg.arg_cols == '0) ||
                               (crop_row_end > (DIM_W+1)'(r_dim)) ||
                               (crop_col_end > (DIM_W+1)'(c_dim));
            end
            default: begin
                arg_err_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.geom) begin
            rc_reg      <= IDX_W'(r_dim) * IDX_W'(c_dim);
            orows_reg   <= orows_next;
            ocols_reg   <= ocols_next;
            arg_err_reg <= arg_err_next;
        end
    end

    // limits check and pull position
    assign out_area = (2*OUT_DIM_W)'(orows_reg) * (2*OUT_DIM_W)'(ocols_reg);

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            err_reg <= arg_err_reg || (orows_reg > COORD_LIMIT) ||
                       (ocols_reg > COORD_LIMIT) || (32'(out_area) > 32'(OUT_MAX));
            if ((OUT_DIM_W'(pull_row_reg) >= orows_reg) ||
                (OUT_DIM_W'(pull_col_reg) >= ocols_reg)) begin
                a_reg <= '0;
                b_reg <= '0;
            end else begin
                a_reg <= pull_row_reg;
                b_reg <= pull_col_reg;
            end
        end
    end

    igt_rem u_rem_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (a_reg),
        .divisor   (r_dim),
        .done      (rem_done_row),
        .remainder (rem_a)
    );

    igt_rem u_rem_col (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (b_reg),
        .divisor   (c_dim),
        .done      (rem_done_col),
        .remainder (rem_b)
    );

    assign rem_done = rem_done_row && rem_done_col;

    // source coordinates
    assign pad_lo     = COORD_W'(cfg.arg_row);
    assign pad_inside = (a_reg >= pad_lo) && (a_reg < pad_lo + COORD_W'(r_dim)) &&
                        (b_reg >= pad_lo) && (b_reg < pad_lo + COORD_W'(c_dim));

    always_comb begin
        src_r_next   = '0;
        src_c_next   = '0;
        pad_sel_next = 1'b0;
        case (cfg.transform_mode)
            MODE_CW: begin
                src_r_next = r_dim - DIM_W'(1) - b_reg[DIM_W-1:0];
                src_c_next = a_reg[DIM_W-1:0];
            end
            MODE_CCW: begin
                src_r_next = b_reg[DIM_W-1:0];
                src_c_next = c_dim - DIM_W'(1) - a_reg[DIM_W-1:0];
            end
            MODE_PAD: begin
                src_r_next   = DIM_W'(a_reg - pad_lo);
                src_c_next   = DIM_W'(b_reg - pad_lo);
                pad_sel_next = !pad_inside;
            end
            MODE_TILE: begin
                src_r_next = rem_a;
                src_c_next = rem_b;
            end
            default: begin
                src_r_next = DIM_W'(cfg.arg_row) + a_reg[DIM_W-1:0];
                src_c_next = DIM_W'(cfg.arg_col) + b_reg[DIM_W-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.src) begin
            src_r_reg   <= src_r_next;
            src_c_reg   <= src_c_next;
            pad_sel_reg <= pad_sel_next;
        end
    end

    assign addr_sum = IDX_W'(src_r_reg) * IDX_W'(c_dim) + IDX_W'(src_c_reg);

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            addr_reg <= AW'(addr_sum);
        end
    end

    // pixel store
    assign load_base = (load_idx_reg >= rc_reg) ? '0 : load_idx_reg;
    assign load_inc  = load_base + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            mem[AW'(load_base)] <= pix_reg;
        end
        if (cmd.read) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg <= '0;
        end else if (cmd.write) begin
            load_idx_reg <= (load_inc >= rc_reg) ? '0 : load_inc;
        end
    end

    // result and pull advance
    assign a_inc   = OUT_DIM_W'(a_reg) + OUT_DIM_W'(1);
    assign b_inc   = OUT_DIM_W'(b_reg) + OUT_DIM_W'(1);
    assign last_px = (a_inc == orows_reg) && (b_inc == ocols_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pull_row_reg <= '0;
            pull_col_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                if (err_reg) begin
                    pull_row_reg <= '0;
                    pull_col_reg <= '0;
                end else if (b_inc < ocols_reg) begin
                    pull_row_reg <= a_reg;
                    pull_col_reg <= COORD_W'(b_inc);
                end else begin
                    pull_col_reg <= '0;
                    pull_row_reg <= (a_inc < orows_reg) ? COORD_W'(a_inc) : '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_err_reg <= err_reg;
            if (err_reg) begin
                m_pix_reg  <= '0;
                m_row_reg  <= '0;
                m_col_reg  <= '0;
                m_last_reg <= 1'b1;
            end else begin
                m_pix_reg  <= pad_sel_reg ? cfg.pad_value : rdata_reg;
                m_row_reg  <= a_reg;
                m_col_reg  <= b_reg;
                m_last_reg <= last_px;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_pix_reg};
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

    assign sts.is_pull  = (op_reg == OP_PULL);
    assign sts.err      = err_reg;
    assign sts.tile     = (cfg.transform_mode == MODE_TILE);
    assign sts.rem_done = rem_done;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign err_item_clean = m_last_reg && (m_pix_reg == '0) && (m_row_reg == '0) &&
                            (m_col_reg == '0);
    assign pull_in_range  = (OUT_DIM_W'(pull_row_reg) < orows_reg) &&
                            (OUT_DIM_W'(pull_col_reg) < ocols_reg);
    assign rem_in_range   = (rem_a < r_dim) && (rem_b < c_dim);

    `IGT_ASSERT_IMP(a_err_result, m_valid_reg && m_err_reg, err_item_clean, "bad error item")
    `IGT_ASSERT_NXT(a_pull_in_range, cmd.out_load && !err_reg, pull_in_range, "pull off image")
    `IGT_ASSERT_IMP(a_rem_range, rem_done, rem_in_range, "tile remainder not below size")

endmodule

// ===== hdl/image_geometric_transform.sv =====
// channel   ports             fields
// input     s_tdata[7:0]      pixel_in
//           s_tuser           opcode (0 load, 1 pull)
// output    m_tdata[31:0]     pixel_out, out_row, out_col
//           m_tlast/m_tuser   last / error
// config    apb, paddr[4:2]   register index
//
// a load runs its steps in order from acceptance: capture, size, store write
// a pull runs its steps in order: capture, size, limit check, plan, source, address, memory read, output
// a tile pull adds a wait state for the bit-serial remainders, both coordinates in parallel;
// an error pull skips source, address and read and goes from plan straight to output
// reset is synchronous on aresetn low; the store keeps no reset and holds garbage until loaded
// a held result waits in the output register while the next item is taken in;
// a pull stalls only in its final cycle when that register is still full

module image_geometric_transform #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int OUT_MAX  = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel_in
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_out, out_row, out_col
    output logic        m_tuser,   // error
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import igt_pkg::*;

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    ctrl_sts_t  sts;
    logic       cfg_we;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_rows     <= DIM_W'(64);
            cfg_reg.image_cols     <= DIM_W'(64);
            cfg_reg.transform_mode <= MODE_CW;
            cfg_reg.arg_row        <= '0;
            cfg_reg.arg_col        <= '0;
            cfg_reg.arg_rows       <= '0;
            cfg_reg.arg_cols       <= '0;
            cfg_reg.pad_value      <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_IMAGE_ROWS: cfg_reg.image_rows     <= pwdata[DIM_W-1:0];
                REG_IMAGE_COLS: cfg_reg.image_cols     <= pwdata[DIM_W-1:0];
                REG_MODE:       cfg_reg.transform_mode <= pwdata[MODE_W-1:0];
                REG_ARG_ROW:    cfg_reg.arg_row        <= pwdata[ARG_W-1:0];
                REG_ARG_COL:    cfg_reg.arg_col        <= pwdata[ARG_W-1:0];
                REG_ARG_ROWS:   cfg_reg.arg_rows       <= pwdata[DIM_W-1:0];
                REG_ARG_COLS:   cfg_reg.arg_cols       <= pwdata[DIM_W-1:0];
                REG_PAD_VALUE:  cfg_reg.pad_value      <= pwdata[PIX_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_ROWS: prdata = 32'(cfg_reg.image_rows);
            REG_IMAGE_COLS: prdata = 32'(cfg_reg.image_cols);
            REG_MODE:       prdata = 32'(cfg_reg.transform_mode);
            REG_ARG_ROW:    prdata = 32'(cfg_reg.arg_row);
            REG_ARG_COL:    prdata = 32'(cfg_reg.arg_col);
            REG_ARG_ROWS:   prdata = 32'(cfg_reg.arg_rows);
            REG_ARG_COLS:   prdata = 32'(cfg_reg.arg_cols);
            REG_PAD_VALUE:  prdata = 32'(cfg_reg.pad_value);
        endcase
    end

    igt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    igt_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .OUT_MAX  (OUT_MAX)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
